// ===== design/stlm_pkg.sv =====
// shared constants and types for the two-list sort and merge block
`timescale 1ns / 1ps

package stlm_pkg;

	// list storage geometry
	localparam int LIST_DEPTH = 32;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = 6;
	localparam int TOT_W      = CNT_W + 1;

	// port field widths
	localparam int VALUE_W    = 32;
	localparam int REQ_W      = 2;

	// request codes carried in the input tuser
	localparam logic [REQ_W-1:0] REQ_APPEND_A = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND_B = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RUN      = 2'd2;

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_SWAP1 = 7'b0000100,
		ST_SWAP2 = 7'b0001000,
		ST_MRD   = 7'b0010000,
		ST_MCMP  = 7'b0100000,
		ST_MWAIT = 7'b1000000
	} state_t;

endpackage

// ===== design/sort_two_lists_and_merge.sv =====
// top level: two list stores, selection sort sequencer and two-way merge
//
// Usage:
//   Input transactions on s_*: tuser holds the request (append to list A,
//   append to list B, run), tdata the value to append. Load list_length
//   values into each list, then send a run request. A run clears both fill
//   counters; appends past LIST_DEPTH entries are dropped.
//   The run sorts A, then B, in place with one shared comparator and one
//   read and one write port per list, then merges them ascending (B first
//   on equal values) and sends 2*min(list_length, LIST_DEPTH) values on m_*,
//   tlast on the final one. Values are sign-extended to 32 bits.
//   Sorting does one compare per cycle over the unsorted tail of each list,
//   drains the last read, then swaps in two states (SWAP1, SWAP2) per
//   position; each merged value then passes read, compare and output
//   register states (MRD, MCMP, MWAIT). s_tready is low while a run is busy.
//   A stalled m_tready holds the output register and pauses the merge.
//   Reset clears fill counters and the sequencer and sets list_length to
//   32; list contents are undefined until loaded. cfg_we should write
//   list_length only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module sort_two_lists_and_merge
	import stlm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [VALUE_W-1:0]  s_tdata,  // value
	input  logic [REQ_W-1:0]    s_tuser,  // req_type
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,  // merged_value
	output logic                m_tlast,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata
);

	state_t state_q;

	logic [CNT_W-1:0] list_length_q;
	logic [CNT_W-1:0] fill_a_q, fill_b_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] i_q, j_q, ia_q, ib_q;
	logic [TOT_W-1:0] k_q;
	logic [IDX_W-1:0] pidx_q, best_q;
	logic             pend_q, sel_b_q;
	logic signed [DATA_WIDTH-1:0] min_q, first_q;
	logic signed [DATA_WIDTH-1:0] out_q;
	logic             out_valid_q, out_last_q;

	// list memories
	logic signed [DATA_WIDTH-1:0] mem_a [LIST_DEPTH];
	logic signed [DATA_WIDTH-1:0] mem_b [LIST_DEPTH];
	logic signed [DATA_WIDTH-1:0] a_rdata, b_rdata, scan_data;
	logic                         a_we, b_we, rd_en;
	logic [IDX_W-1:0]             a_waddr, b_waddr, a_raddr, b_raddr;
	logic signed [DATA_WIDTH-1:0] wdata;

	logic accept;
	logic [CNT_W-1:0] run_len;
	logic [TOT_W-1:0] total;
	logic take_a;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = VALUE_W'(out_q);
	assign m_tlast   = out_last_q;
	assign scan_data = sel_b_q ? b_rdata : a_rdata;
	assign total     = {len_q, 1'b0};

	// clamp the configured length to the store depth
	assign run_len = (list_length_q > CNT_W'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH) : list_length_q;

	// merge choice: A when it has entries left and B is exhausted or A's head is strictly smaller
	assign take_a = (ia_q < len_q) && ((ib_q >= len_q) || (a_rdata < b_rdata));

	// memory port control
	always_comb begin
		a_we    = 1'b0;
		b_we    = 1'b0;
		a_waddr = fill_a_q[IDX_W-1:0];
		b_waddr = fill_b_q[IDX_W-1:0];
		wdata   = s_tdata[DATA_WIDTH-1:0];
		rd_en   = 1'b0;
		a_raddr = j_q[IDX_W-1:0];
		b_raddr = j_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser == REQ_APPEND_A && fill_a_q < CNT_W'(LIST_DEPTH))
					a_we = 1'b1;
				if (accept && s_tuser == REQ_APPEND_B && fill_b_q < CNT_W'(LIST_DEPTH))
					b_we = 1'b1;
			end
			ST_SCAN: begin
				rd_en = (j_q < len_q);
			end
			ST_SWAP1: begin
				a_we    = !sel_b_q;
				b_we    = sel_b_q;
				a_waddr = i_q[IDX_W-1:0];
				b_waddr = i_q[IDX_W-1:0];
				wdata   = min_q;
			end
			ST_SWAP2: begin
				a_we    = !sel_b_q;
				b_we    = sel_b_q;
				a_waddr = best_q;
				b_waddr = best_q;
				wdata   = first_q;
			end
			ST_MRD: begin
				rd_en   = 1'b1;
				a_raddr = ia_q[IDX_W-1:0];
				b_raddr = ib_q[IDX_W-1:0];
			end
			ST_MCMP, ST_MWAIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we)
			mem_a[a_waddr] <= wdata;
		if (rd_en)
			a_rdata <= mem_a[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			mem_b[b_waddr] <= wdata;
		if (rd_en)
			b_rdata <= mem_b[b_raddr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_length_q <= CNT_W'(32);
		end else if (cfg_we) begin
			list_length_q <= cfg_wdata;
		end
	end

	// sequencer: load, sort each list, merge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_a_q    <= '0;
			fill_b_q    <= '0;
			len_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			ia_q        <= '0;
			ib_q        <= '0;
			k_q         <= '0;
			pend_q      <= 1'b0;
			sel_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (a_we)
						fill_a_q <= fill_a_q + 1'b1;
					if (b_we)
						fill_b_q <= fill_b_q + 1'b1;
					if (accept && s_tuser == REQ_RUN) begin
						fill_a_q <= '0;
						fill_b_q <= '0;
						len_q    <= run_len;
						i_q      <= '0;
						j_q      <= '0;
						pend_q   <= 1'b0;
						sel_b_q  <= 1'b0;
						if (run_len != '0)
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one read per cycle over the unsorted tail
					if (j_q < len_q) begin
						j_q    <= j_q + 1'b1;
						pidx_q <= j_q[IDX_W-1:0];
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					// shared compare on the returned entry
					if (pend_q) begin
						if (pidx_q == i_q[IDX_W-1:0]) begin
							min_q   <= scan_data;
							first_q <= scan_data;
							best_q  <= pidx_q;
						end else if (scan_data < min_q) begin
							min_q  <= scan_data;
							best_q <= pidx_q;
						end
					end
					if (j_q >= len_q && !pend_q)
						state_q <= ST_SWAP1;
				end
				ST_SWAP1: begin
					state_q <= ST_SWAP2;
				end
				ST_SWAP2: begin
					if (i_q + 1'b1 < len_q) begin
						i_q     <= i_q + 1'b1;
						j_q     <= i_q + 1'b1;
						state_q <= ST_SCAN;
					end else if (!sel_b_q) begin
						sel_b_q <= 1'b1;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_SCAN;
					end else begin
						ia_q    <= '0;
						ib_q    <= '0;
						k_q     <= '0;
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					state_q <= ST_MCMP;
				end
				ST_MCMP: begin
					// pick the next merged value into the output register
					if (take_a) begin
						out_q <= a_rdata;
						ia_q  <= ia_q + 1'b1;
					end else begin
						out_q <= b_rdata;
						ib_q  <= ib_q + 1'b1;
					end
					out_last_q  <= (k_q == total - 1'b1);
					k_q         <= k_q + 1'b1;
					out_valid_q <= 1'b1;
					state_q     <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= out_last_q ? ST_IDLE : ST_MRD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sim/tb.sv =====
// testbench for the two-list sort and merge block: random loads and runs against a predictor
`timescale 1ns / 1ps

module tb;
	import stlm_pkg::*;

	// request code the block must ignore
	localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

	// cycles the block may stay busy after a request with no result
	localparam int SETTLE = 2000;
	// long receiver hold-off in cycles
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [REQ_W-1:0]   req;
		logic [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} merged_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [VALUE_W-1:0]  s_tdata = '0;   // value
	logic [REQ_W-1:0]    s_tuser = '0;   // req_type
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [VALUE_W-1:0]  m_tdata;        // merged_value
	logic                m_tlast;
	logic                cfg_we = 1'b0;
	logic [CNT_W-1:0]    cfg_wdata = '0;

	sort_two_lists_and_merge dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always #2 clk = ~clk;

	// pending requests and merged values still to come
	req_item_t req_q [$];
	merged_t   merge_q [$];

	// predictor state: list contents, fill positions and the length register
	logic signed [DATA_WIDTH-1:0] lists [2][LIST_DEPTH];
	int                           fill [2] = '{0, 0};
	logic [CNT_W-1:0]             cur_len = 6'd32;

	// stimulus-side view of which entries were ever written
	int load_fill [2] = '{0, 0};
	int load_seen [2] = '{0, 0};
	int phase_items;

	// idling controls
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	// bookkeeping
	bit        in_taken = 1'b0;
	req_item_t cur;
	merged_t   want;
	int        err_cnt = 0;
	int        accepted = 0;
	int        runs = 0;
	int        checked = 0;

	// work out the merged values that one request causes
	task automatic apply_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] value);
		int l, i, j, best, n, ia, ib;
		logic signed [DATA_WIDTH-1:0] t;
		logic signed [DATA_WIDTH-1:0] pick;
		merged_t m;
		case (req)
			REQ_APPEND_A, REQ_APPEND_B: begin
				l = (req == REQ_APPEND_B) ? 1 : 0;
				if (fill[l] < LIST_DEPTH) begin
					lists[l][fill[l]] = value[DATA_WIDTH-1:0];
					fill[l]++;
				end
			end
			REQ_RUN: begin
				runs++;
				fill[0] = 0;
				fill[1] = 0;
				n = (cur_len > LIST_DEPTH) ? LIST_DEPTH : int'(cur_len);
				// selection sort of both lists in place
				for (l = 0; l < 2; l++) begin
					for (i = 0; i < n; i++) begin
						best = i;
						for (j = i; j < n; j++)
							if (lists[l][j] < lists[l][best])
								best = j;
						t = lists[l][i];
						lists[l][i] = lists[l][best];
						lists[l][best] = t;
					end
				end
				// two-way merge, list b wins on equal heads
				ia = 0;
				ib = 0;
				for (i = 0; i < 2 * n; i++) begin
					if (ia < n && (ib >= n || lists[0][ia] < lists[1][ib])) begin
						pick = lists[0][ia];
						ia++;
					end else begin
						pick = lists[1][ib];
						ib++;
					end
					m.value = pick;
					m.last = (i == 2 * n - 1);
					merge_q.push_back(m);
				end
			end
			default: ;
		endcase
	endtask

	// input side: take the predicted results of each accepted transaction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			apply_request(s_tuser, s_tdata);
			accepted++;
			in_taken = 1'b1;
		end
	end

	// driver: next request or an idle cycle
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			in_taken = 1'b0;
			if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cur = req_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur.req;
				s_tdata <= cur.value;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready, with random stalls and a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// output side: compare each transaction with the oldest expected value
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (merge_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected output: value %h last %b", m_tdata, m_tlast);
			end else begin
				want = merge_q.pop_front();
				checked++;
				if (m_tdata !== want.value || m_tlast !== want.last) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: expected value %h last %b, got value %h last %b",
							want.value, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	// queue a request and track the fill positions on the stimulus side
	task automatic push_req(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] value);
		req_item_t it;
		int l;
		it.req = req;
		it.value = value;
		req_q.push_back(it);
		phase_items++;
		if (req == REQ_APPEND_A || req == REQ_APPEND_B) begin
			l = (req == REQ_APPEND_B) ? 1 : 0;
			if (load_fill[l] < LIST_DEPTH)
				load_fill[l]++;
			if (load_fill[l] > load_seen[l])
				load_seen[l] = load_fill[l];
		end else if (req == REQ_RUN) begin
			load_fill[0] = 0;
			load_fill[1] = 0;
		end
	endtask

	// values biased toward extremes and small repeats
	function automatic logic [VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return VALUE_W'($urandom_range(0, 8) - 4);
			default: return $urandom;
		endcase
	endfunction

	// wait until the block is idle, then write the length register
	task automatic set_length(input logic [CNT_W-1:0] v);
		do
			@(negedge clk);
		while (req_q.size() != 0 || s_tvalid || merge_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		cur_len = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// load both lists (full, partial over stale entries, or overfull) and run
	task automatic load_and_run(input int n, input int overfill);
		int cnt [2];
		int l, r;
		for (l = 0; l < 2; l++) begin
			r = $urandom_range(0, 9);
			if (load_seen[l] >= n && (n > 8 || r == 7))
				cnt[l] = $urandom_range(0, (n > 8) ? 4 : n);
			else if (r == 8)
				cnt[l] = n + $urandom_range(1, 3);
			else
				cnt[l] = n;
			cnt[l] += overfill;
		end
		while (cnt[0] + cnt[1] > 0) begin
			if ($urandom_range(0, 9) == 0)
				push_req(REQ_NONE, $urandom);
			l = ($urandom_range(0, cnt[0] + cnt[1] - 1) < cnt[0]) ? 0 : 1;
			push_req(l ? REQ_APPEND_B : REQ_APPEND_A, rand_value());
			cnt[l]--;
		end
		push_req(REQ_RUN, $urandom);
	endtask

	// one phase: length setting, idling mode, then sequences up to a budget
	task automatic run_phase(input logic [CNT_W-1:0] len, input int mode, input int budget,
			input int overfill, input bit long_hold);
		set_length(len);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
			default: begin send_idle_pct = 18; recv_stall_pct = 18; end
		endcase
		if (long_hold)
			hold_req = 1'b1;
		phase_items = 0;
		do
			load_and_run((len > LIST_DEPTH) ? LIST_DEPTH : int'(len), overfill);
		while (phase_items < budget);
	endtask

	// main sequence
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length one: both extremes, an ignored request, then a rerun on stale entries
		set_length(6'd1);
		push_req(REQ_APPEND_A, 32'h8000_0000);
		push_req(REQ_APPEND_B, 32'h7fff_ffff);
		push_req(REQ_NONE, 32'hffff_ffff);
		push_req(REQ_RUN, '0);
		push_req(REQ_RUN, 32'hffff_ffff);

		// length zero: run gives nothing but clears the fill positions
		set_length(6'd0);
		push_req(REQ_APPEND_A, 32'h5555_aaaa);
		push_req(REQ_RUN, '0);

		// length two: equal heads across the lists
		set_length(6'd2);
		push_req(REQ_APPEND_A, 32'd7);
		push_req(REQ_APPEND_B, 32'd7);
		push_req(REQ_APPEND_A, 32'd7);
		push_req(REQ_APPEND_B, 32'hffff_ffff);
		push_req(REQ_RUN, '0);

		// random phases
		run_phase(CNT_W'($urandom_range(1, 4)), 0, 50, 0, 1'b0);
		run_phase(6'd32, 1, 1, 2, 1'b0);
		run_phase(6'd63, 2, 30, 0, 1'b1);
		run_phase(6'd0, 3, 15, 0, 1'b0);
		run_phase(CNT_W'($urandom_range(5, 12)), 3, 60, 0, 1'b0);
		run_phase(CNT_W'($urandom_range(1, 8)), 1, 60, 0, 1'b0);
		run_phase(CNT_W'($urandom_range(1, 8)), 2, 60, 0, 1'b1);
		run_phase(CNT_W'($urandom_range(33, 62)), 0, 20, 0, 1'b0);
		run_phase(6'd1, 3, 20, 0, 1'b0);

		// drain and let any stray output show up
		do
			@(negedge clk);
		while (req_q.size() != 0 || s_tvalid || merge_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
		if (merge_q.size() != 0) begin
			err_cnt += merge_q.size();
			$display("%0d expected values never arrived", merge_q.size());
		end

		$display("covered %0d requests and %0d runs, %0d merged values checked", accepted, runs,
			checked);
		$display("lengths 0 to 63 with stale, partial and overfull loads, %0d errors", err_cnt);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout");
		$display("FAIL");
		$finish;
	end

endmodule
